### hdl/amfm_pkg.sv
// Shared types, codes and constants for the AM/FM tuner panel controller.
`default_nettype none

package amfm_pkg;

  localparam int STATION_W = 11;
  localparam int VOLUME_W  = 7;
  localparam int VREQ_W    = 11;
  localparam int BUTTON_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;

  localparam int PRESET_COUNT_DEF = 5;
  localparam int AM_STEP_DEF      = 10;
  localparam int FM_STEP_DEF      = 2;

  localparam logic [STATION_W-1:0] AM_LOWEST_RST  = 11'd530;
  localparam logic [STATION_W-1:0] AM_HIGHEST_RST = 11'd1700;
  localparam logic [STATION_W-1:0] FM_LOWEST_RST  = 11'd879;
  localparam logic [STATION_W-1:0] FM_HIGHEST_RST = 11'd1079;
  localparam logic [VOLUME_W-1:0]  VOL_CEIL_RST   = 7'd100;

  typedef enum logic [2:0] {
    REQ_POWER,
    REQ_BAND,
    REQ_SCAN_UP,
    REQ_SCAN_DOWN,
    REQ_SET_STATION,
    REQ_SET_VOLUME,
    REQ_STORE,
    REQ_RECALL
  } req_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_REJECT,
    ST_ZERO,
    ST_CEIL
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AM_LOWEST,
    CFG_AM_HIGHEST,
    CFG_FM_LOWEST,
    CFG_FM_HIGHEST,
    CFG_VOL_CEILING
  } cfg_idx_t;

endpackage

`default_nettype wire

### hdl/am_fm_tuner_panel_controller.sv
// Top level of the AM/FM tuner front-panel controller.
`default_nettype none

// One panel request word is taken every cycle while the result side keeps up. A word
// is held in the input register and then applied to the tuner state, whose registers
// drive the result word; the single update stage (compare, add and select on the current
// state) sets the rate of one word per cycle. A stalled result word holds the tuner state,
// and the input stalls once the input register is occupied as well.
// The result word reports the status together with the tuner settings after the request.
module am_fm_tuner_panel_controller #(
  parameter int PRESET_COUNT = amfm_pkg::PRESET_COUNT_DEF,
  parameter int AM_STEP      = amfm_pkg::AM_STEP_DEF,
  parameter int FM_STEP      = amfm_pkg::FM_STEP_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [amfm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [amfm_pkg::CFG_DAT_W-1:0]        cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [2:0]                            in_req_type,
  input  wire logic [amfm_pkg::STATION_W-1:0]        in_station_value,
  input  wire logic signed [amfm_pkg::VREQ_W-1:0]    in_volume_value,
  input  wire logic [amfm_pkg::BUTTON_W-1:0]         in_button_index,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [1:0]                                 out_status,
  output logic                                       out_power_on,
  output logic                                       out_band_fm,
  output logic [amfm_pkg::STATION_W-1:0]             out_station_now,
  output logic [amfm_pkg::VOLUME_W-1:0]              out_volume_now
);

  localparam int SW      = amfm_pkg::STATION_W;
  localparam int VW      = amfm_pkg::VOLUME_W;
  localparam int PIDX_W  = (PRESET_COUNT > 1) ? $clog2(PRESET_COUNT) : 1;
  localparam int DIV_SH  = SW + $clog2(AM_STEP) + 1;
  localparam int AM_MUL  = ((2 ** DIV_SH) + AM_STEP - 1) / AM_STEP;
  localparam int PROD_W  = SW + DIV_SH + 1;

  // Input register.
  logic                   s1_valid_r;
  logic [2:0]             req_r;
  logic [SW-1:0]          sval_r;
  logic signed [amfm_pkg::VREQ_W-1:0] vval_r;
  logic [amfm_pkg::BUTTON_W-1:0]      btn_r;

  // Configuration registers.
  logic [SW-1:0] am_lo_r, am_hi_r, fm_lo_r, fm_hi_r;
  logic [VW-1:0] vol_ceil_r;

  // Tuner state.
  logic          powered_r, powered_nxt;
  logic          band_r, band_nxt;
  logic [SW-1:0] station_r, station_nxt;
  logic [VW-1:0] volume_r, volume_nxt;
  logic [VW-1:0] saved_vol_r, saved_vol_nxt;
  logic [SW-1:0] last_am_r, last_am_nxt;
  logic [SW-1:0] last_fm_r, last_fm_nxt;
  logic [SW-1:0] am_pre_r [PRESET_COUNT];
  logic [SW-1:0] am_pre_nxt [PRESET_COUNT];
  logic [SW-1:0] fm_pre_r [PRESET_COUNT];
  logic [SW-1:0] fm_pre_nxt [PRESET_COUNT];

  logic                  out_valid_r;
  amfm_pkg::status_t     status_r, status_nxt;

  logic                  advance;
  logic [SW-1:0]         lo, hi;
  logic [SW:0]           step;
  logic [SW:0]           up_sum;
  logic [PROD_W-1:0]     am_prod;
  logic                  am_on_grid;
  logic                  btn_ok;
  logic [PIDX_W-1:0]     pidx;
  logic                  vol_neg, vol_over;
  logic [VW-1:0]         restore_vol;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  assign lo   = band_r ? fm_lo_r : am_lo_r;
  assign hi   = band_r ? fm_hi_r : am_hi_r;
  assign step = band_r ? (SW+1)'(FM_STEP) : (SW+1)'(AM_STEP);
  assign up_sum = {1'b0, station_r} + step;

  // Multiple-of-step test: the fraction of the reciprocal product stays small only
  // for exact multiples.
  assign am_prod    = PROD_W'(sval_r) * PROD_W'(AM_MUL);
  assign am_on_grid = {1'b0, am_prod[DIV_SH-1:0]} < (DIV_SH+1)'(AM_MUL);

  assign btn_ok = {1'b0, btn_r} < (amfm_pkg::BUTTON_W+1)'(PRESET_COUNT);
  assign pidx   = btn_r[PIDX_W-1:0];

  assign vol_neg  = vval_r[amfm_pkg::VREQ_W-1];
  assign vol_over = !vol_neg &&
                    (vval_r[amfm_pkg::VREQ_W-2:0] > (amfm_pkg::VREQ_W-1)'(vol_ceil_r));
  assign restore_vol = (saved_vol_r > vol_ceil_r) ? vol_ceil_r : saved_vol_r;

  always_comb begin
    powered_nxt   = powered_r;
    band_nxt      = band_r;
    station_nxt   = station_r;
    volume_nxt    = volume_r;
    saved_vol_nxt = saved_vol_r;
    last_am_nxt   = last_am_r;
    last_fm_nxt   = last_fm_r;
    am_pre_nxt    = am_pre_r;
    fm_pre_nxt    = fm_pre_r;
    status_nxt    = amfm_pkg::ST_OK;
    case (req_r)
      amfm_pkg::REQ_POWER: begin
        if (!powered_r) begin
          powered_nxt = 1'b1;
          station_nxt = band_r ? last_fm_r : last_am_r;
          volume_nxt  = restore_vol;
        end else begin
          saved_vol_nxt = volume_r;
          volume_nxt    = '0;
          if (band_r) begin
            last_fm_nxt = station_r;
          end else begin
            last_am_nxt = station_r;
          end
          powered_nxt = 1'b0;
        end
      end
      amfm_pkg::REQ_BAND: begin
        if (band_r) begin
          last_fm_nxt = station_r;
          station_nxt = last_am_r;
        end else begin
          last_am_nxt = station_r;
          station_nxt = last_fm_r;
        end
        band_nxt = !band_r;
      end
      amfm_pkg::REQ_SCAN_UP: begin
        if (station_r >= hi || up_sum[SW]) begin
          station_nxt = lo;
        end else begin
          station_nxt = up_sum[SW-1:0];
        end
      end
      amfm_pkg::REQ_SCAN_DOWN: begin
        if (station_r <= lo || {1'b0, station_r} < step) begin
          station_nxt = hi;
        end else begin
          station_nxt = station_r - step[SW-1:0];
        end
      end
      amfm_pkg::REQ_SET_STATION: begin
        if (sval_r >= lo && sval_r <= hi && (band_r || am_on_grid)) begin
          station_nxt = sval_r;
        end else begin
          status_nxt = amfm_pkg::ST_REJECT;
        end
      end
      amfm_pkg::REQ_SET_VOLUME: begin
        if (!powered_r) begin
          status_nxt = amfm_pkg::ST_REJECT;
        end else if (vol_neg) begin
          volume_nxt = '0;
          status_nxt = amfm_pkg::ST_ZERO;
        end else if (vol_over) begin
          volume_nxt = vol_ceil_r;
          status_nxt = amfm_pkg::ST_CEIL;
        end else begin
          volume_nxt = vval_r[VW-1:0];
        end
      end
      amfm_pkg::REQ_STORE: begin
        if (btn_ok) begin
          if (band_r) begin
            fm_pre_nxt[pidx] = station_r;
          end else begin
            am_pre_nxt[pidx] = station_r;
          end
        end else begin
          status_nxt = amfm_pkg::ST_REJECT;
        end
      end
      amfm_pkg::REQ_RECALL: begin
        if (btn_ok) begin
          station_nxt = band_r ? fm_pre_r[pidx] : am_pre_r[pidx];
        end else begin
          status_nxt = amfm_pkg::ST_REJECT;
        end
      end
      default: begin
        status_nxt = amfm_pkg::ST_REJECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      am_lo_r    <= amfm_pkg::AM_LOWEST_RST;
      am_hi_r    <= amfm_pkg::AM_HIGHEST_RST;
      fm_lo_r    <= amfm_pkg::FM_LOWEST_RST;
      fm_hi_r    <= amfm_pkg::FM_HIGHEST_RST;
      vol_ceil_r <= amfm_pkg::VOL_CEIL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        amfm_pkg::CFG_AM_LOWEST:   am_lo_r    <= cfg_wdata[SW-1:0];
        amfm_pkg::CFG_AM_HIGHEST:  am_hi_r    <= cfg_wdata[SW-1:0];
        amfm_pkg::CFG_FM_LOWEST:   fm_lo_r    <= cfg_wdata[SW-1:0];
        amfm_pkg::CFG_FM_HIGHEST:  fm_hi_r    <= cfg_wdata[SW-1:0];
        amfm_pkg::CFG_VOL_CEILING: vol_ceil_r <= cfg_wdata[VW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r  <= in_req_type;
      sval_r <= in_station_value;
      vval_r <= in_volume_value;
      btn_r  <= in_button_index;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r    <= amfm_pkg::ST_OK;
      powered_r   <= 1'b0;
      band_r      <= 1'b0;
      station_r   <= amfm_pkg::AM_LOWEST_RST;
      volume_r    <= '0;
      saved_vol_r <= '0;
      last_am_r   <= amfm_pkg::AM_LOWEST_RST;
      last_fm_r   <= amfm_pkg::FM_LOWEST_RST;
      for (int i = 0; i < PRESET_COUNT; i++) begin
        am_pre_r[i] <= amfm_pkg::AM_LOWEST_RST;
        fm_pre_r[i] <= amfm_pkg::FM_LOWEST_RST;
      end
    end else if (advance) begin
      out_valid_r <= 1'b1;
      status_r    <= status_nxt;
      powered_r   <= powered_nxt;
      band_r      <= band_nxt;
      station_r   <= station_nxt;
      volume_r    <= volume_nxt;
      saved_vol_r <= saved_vol_nxt;
      last_am_r   <= last_am_nxt;
      last_fm_r   <= last_fm_nxt;
      am_pre_r    <= am_pre_nxt;
      fm_pre_r    <= fm_pre_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_power_on    = powered_r;
  assign out_band_fm     = band_r;
  assign out_station_now = station_r;
  assign out_volume_now  = volume_r;

endmodule

`default_nettype wire

### hdl/amfm_chk.sv
// Port-level checker for the AM/FM tuner panel controller, with its bind statement.
`default_nettype none

module amfm_chk (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic [1:0]                            out_status,
  input wire logic                                  out_power_on,
  input wire logic                                  out_band_fm,
  input wire logic [amfm_pkg::STATION_W-1:0]        out_station_now,
  input wire logic [amfm_pkg::VOLUME_W-1:0]         out_volume_now
);

  // A stalled result word stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_station_now) && $stable(out_volume_now) && $stable(out_power_on) &&
      $stable(out_band_fm))
    else $error("result word changed while stalled");

  // The radio is muted whenever it is off.
  a_off_muted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_power_on |-> out_volume_now == '0)
    else $error("volume not zero while off");

  // A clamped volume result is only possible while on, and clamping low gives zero.
  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == amfm_pkg::ST_ZERO |-> out_power_on && out_volume_now == '0)
    else $error("bad clamp-to-zero result");

  a_clamp_ceil: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == amfm_pkg::ST_CEIL |-> out_power_on)
    else $error("ceiling clamp reported while off");

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind am_fm_tuner_panel_controller amfm_chk u_amfm_chk (.*);

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the AM/FM tuner panel controller, with directed and random words.
module tb_top;

  localparam int PRESETS = amfm_pkg::PRESET_COUNT_DEF;
  localparam int AMSTEP = amfm_pkg::AM_STEP_DEF;
  localparam int FMSTEP = amfm_pkg::FM_STEP_DEF;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 150;
  localparam int SW = amfm_pkg::STATION_W;
  localparam int VW = amfm_pkg::VOLUME_W;
  localparam int VRW = amfm_pkg::VREQ_W;
  localparam int BW = amfm_pkg::BUTTON_W;
  localparam int CIW = amfm_pkg::CFG_IDX_W;
  localparam int CDW = amfm_pkg::CFG_DAT_W;
  localparam int PIDX_W = (PRESETS > 1) ? $clog2(PRESETS) : 1;

  typedef struct packed {
    amfm_pkg::status_t      status;
    logic                   power;
    logic                   fm;
    logic [SW-1:0]          station;
    logic [VW-1:0]          volume;
  } panel_word_t;

  typedef struct packed {
    amfm_pkg::req_t         req;
    logic [SW-1:0]          sval;
    logic [VRW-1:0]         vraw;
    logic [BW-1:0]          btn;
    logic                   typed;
    panel_word_t            want;
  } drill_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CIW-1:0]           cfg_index;
  logic [CDW-1:0]           cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               in_req_type;
  logic [SW-1:0]            in_station_value;
  logic signed [VRW-1:0]    in_volume_value;
  logic [BW-1:0]            in_button_index;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               out_status;
  logic                     out_power_on;
  logic                     out_band_fm;
  logic [SW-1:0]            out_station_now;
  logic [VW-1:0]            out_volume_now;

  am_fm_tuner_panel_controller dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_station_value (in_station_value),
    .in_volume_value  (in_volume_value),
    .in_button_index  (in_button_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_power_on     (out_power_on),
    .out_band_fm      (out_band_fm),
    .out_station_now  (out_station_now),
    .out_volume_now   (out_volume_now)
  );

  // Tuner state as the panel should hold it.
  logic                 powered;
  logic                 on_fm;
  logic [SW-1:0]        tuned;
  logic [VW-1:0]        loudness;
  logic [VW-1:0]        parked_loudness;
  logic [SW-1:0]        last_am;
  logic [SW-1:0]        last_fm;
  logic [SW-1:0]        am_preset [PRESETS];
  logic [SW-1:0]        fm_preset [PRESETS];
  logic [SW-1:0]        am_lo, am_hi, fm_lo, fm_hi;
  logic [VW-1:0]        vol_ceil;

  panel_word_t pending_words [$];
  int bad_fields = 0;
  int sent_words = 0;
  int checked_words = 0;
  int squeeze_asks = 0;
  int squeeze_served = 0;

  drill_row_t drill_table [26] = '{
    '{amfm_pkg::REQ_SET_VOLUME,  11'd50,   11'd50,  4'd0,  1'b1,
      '{amfm_pkg::ST_REJECT, 1'b0, 1'b0, 11'd530, 7'd0}},
    '{amfm_pkg::REQ_STORE,       11'd2047, 11'd0,   4'd15, 1'b1,
      '{amfm_pkg::ST_REJECT, 1'b0, 1'b0, 11'd530, 7'd0}},
    '{amfm_pkg::REQ_RECALL,      11'd0,    11'h7FF, 4'd5,  1'b1,
      '{amfm_pkg::ST_REJECT, 1'b0, 1'b0, 11'd530, 7'd0}},
    '{amfm_pkg::REQ_SET_STATION, 11'd535,  11'd0,   4'd0,  1'b1,
      '{amfm_pkg::ST_REJECT, 1'b0, 1'b0, 11'd530, 7'd0}},
    '{amfm_pkg::REQ_SET_STATION, 11'd0,    11'd0,   4'd0,  1'b1,
      '{amfm_pkg::ST_REJECT, 1'b0, 1'b0, 11'd530, 7'd0}},
    '{amfm_pkg::REQ_SCAN_DOWN,   11'd0,    11'd0,   4'd0,  1'b1,
      '{amfm_pkg::ST_OK, 1'b0, 1'b0, 11'd1700, 7'd0}},
    '{amfm_pkg::REQ_SCAN_UP,     11'd0,    11'd0,   4'd0,  1'b1,
      '{amfm_pkg::ST_OK, 1'b0, 1'b0, 11'd530, 7'd0}},
    '{amfm_pkg::REQ_POWER,       11'd0,    11'd0,   4'd0,  1'b1,
      '{amfm_pkg::ST_OK, 1'b1, 1'b0, 11'd530, 7'd0}},
    '{amfm_pkg::REQ_SET_VOLUME,  11'd0,    11'h400, 4'd0,  1'b1,
      '{amfm_pkg::ST_ZERO, 1'b1, 1'b0, 11'd530, 7'd0}},
    '{amfm_pkg::REQ_SET_VOLUME,  11'd0,    11'h3FF, 4'd0,  1'b1,
      '{amfm_pkg::ST_CEIL, 1'b1, 1'b0, 11'd530, 7'd100}},
    '{amfm_pkg::REQ_SET_VOLUME,  11'd0,    11'd0,   4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_SET_VOLUME,  11'd0,    11'd100, 4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_SET_STATION, 11'd1700, 11'd0,   4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_STORE,       11'd0,    11'd0,   4'd4,  1'b0, '0},
    '{amfm_pkg::REQ_BAND,        11'd0,    11'd0,   4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_SET_STATION, 11'd2047, 11'd0,   4'd0,  1'b1,
      '{amfm_pkg::ST_REJECT, 1'b1, 1'b1, 11'd879, 7'd100}},
    '{amfm_pkg::REQ_SET_STATION, 11'd1001, 11'd0,   4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_SCAN_UP,     11'd0,    11'd0,   4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_STORE,       11'd0,    11'd0,   4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_SCAN_DOWN,   11'd0,    11'd0,   4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_RECALL,      11'd0,    11'd0,   4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_POWER,       11'd0,    11'd0,   4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_SET_VOLUME,  11'd0,    11'd20,  4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_BAND,        11'd0,    11'd0,   4'd0,  1'b0, '0},
    '{amfm_pkg::REQ_RECALL,      11'd0,    11'd0,   4'd4,  1'b0, '0},
    '{amfm_pkg::REQ_POWER,       11'd0,    11'd0,   4'd0,  1'b0, '0}
  };

  logic [CDW-1:0] limit_sets [6][5] = '{
    '{11'd0,    11'd2047, 11'd0,    11'd2047, 11'd127},
    '{11'd1700, 11'd530,  11'd1079, 11'd879,  11'd1},
    '{11'd2000, 11'd2047, 11'd2039, 11'd2047, 11'd127},
    '{11'd3,    11'd60,   11'd1,    11'd9,    11'd5},
    '{11'd0,    11'd100,  11'd0,    11'd20,   11'd63},
    '{11'd530,  11'd1700, 11'd879,  11'd1079, 11'd100}
  };

  function automatic void reset_tuner();
    powered = 1'b0;
    on_fm = 1'b0;
    tuned = amfm_pkg::AM_LOWEST_RST;
    loudness = '0;
    parked_loudness = '0;
    last_am = amfm_pkg::AM_LOWEST_RST;
    last_fm = amfm_pkg::FM_LOWEST_RST;
    for (int i = 0; i < PRESETS; i++) begin
      am_preset[i] = amfm_pkg::AM_LOWEST_RST;
      fm_preset[i] = amfm_pkg::FM_LOWEST_RST;
    end
    am_lo = amfm_pkg::AM_LOWEST_RST;
    am_hi = amfm_pkg::AM_HIGHEST_RST;
    fm_lo = amfm_pkg::FM_LOWEST_RST;
    fm_hi = amfm_pkg::FM_HIGHEST_RST;
    vol_ceil = amfm_pkg::VOL_CEIL_RST;
  endfunction

  function automatic amfm_pkg::status_t set_loudness(int v);
    if (v < 0) begin
      loudness = '0;
      return amfm_pkg::ST_ZERO;
    end
    if (v > int'(vol_ceil)) begin
      loudness = vol_ceil;
      return amfm_pkg::ST_CEIL;
    end
    loudness = v[VW-1:0];
    return amfm_pkg::ST_OK;
  endfunction

  function automatic panel_word_t tune_request(amfm_pkg::req_t req, logic [SW-1:0] sval,
                                               logic [VRW-1:0] vraw,
                                               logic [BW-1:0] btn);
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    int step;
    amfm_pkg::status_t st;
    panel_word_t w;
    lo = on_fm ? fm_lo : am_lo;
    hi = on_fm ? fm_hi : am_hi;
    step = on_fm ? FMSTEP : AMSTEP;
    st = amfm_pkg::ST_OK;
    case (req)
      amfm_pkg::REQ_POWER: begin
        if (!powered) begin
          powered = 1'b1;
          tuned = on_fm ? last_fm : last_am;
          void'(set_loudness(int'(parked_loudness)));
        end else begin
          parked_loudness = loudness;
          loudness = '0;
          if (on_fm) last_fm = tuned;
          else last_am = tuned;
          powered = 1'b0;
        end
      end
      amfm_pkg::REQ_BAND: begin
        if (on_fm) begin
          last_fm = tuned;
          tuned = last_am;
        end else begin
          last_am = tuned;
          tuned = last_fm;
        end
        on_fm = !on_fm;
      end
      amfm_pkg::REQ_SCAN_UP: begin
        if (tuned >= hi || int'(tuned) + step > 2047) tuned = lo;
        else tuned = tuned + SW'(step);
      end
      amfm_pkg::REQ_SCAN_DOWN: begin
        if (tuned <= lo || int'(tuned) < step) tuned = hi;
        else tuned = tuned - SW'(step);
      end
      amfm_pkg::REQ_SET_STATION: begin
        if (sval >= lo && sval <= hi && (on_fm || int'(sval) % AMSTEP == 0)) tuned = sval;
        else st = amfm_pkg::ST_REJECT;
      end
      amfm_pkg::REQ_SET_VOLUME: begin
        if (powered) st = set_loudness(int'($signed(vraw)));
        else st = amfm_pkg::ST_REJECT;
      end
      amfm_pkg::REQ_STORE: begin
        if (int'(btn) < PRESETS) begin
          if (on_fm) fm_preset[btn[PIDX_W-1:0]] = tuned;
          else am_preset[btn[PIDX_W-1:0]] = tuned;
        end else begin
          st = amfm_pkg::ST_REJECT;
        end
      end
      default: begin
        if (int'(btn) < PRESETS)
          tuned = on_fm ? fm_preset[btn[PIDX_W-1:0]] : am_preset[btn[PIDX_W-1:0]];
        else st = amfm_pkg::ST_REJECT;
      end
    endcase
    w = '{st, powered, on_fm, tuned, loudness};
    return w;
  endfunction

  task automatic flag_field(string what, int got, int want);
    bad_fields++;
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic send_word(amfm_pkg::req_t req, logic [SW-1:0] sval, logic [VRW-1:0] vraw,
                           logic [BW-1:0] btn, logic typed, panel_word_t want);
    panel_word_t guess;
    @(negedge clk);
    in_valid = 1'b1;
    in_req_type = req;
    in_station_value = sval;
    in_volume_value = vraw;
    in_button_index = btn;
    do begin
      @(posedge clk);
    end while (in_stall);
    guess = tune_request(req, sval, vraw, btn);
    pending_words.push_back(typed ? want : guess);
    sent_words++;
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    idle_sender(1);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_limits(logic [CDW-1:0] vals [5]);
    amfm_pkg::cfg_idx_t order [5];
    order = '{amfm_pkg::CFG_AM_LOWEST, amfm_pkg::CFG_AM_HIGHEST, amfm_pkg::CFG_FM_LOWEST,
              amfm_pkg::CFG_FM_HIGHEST, amfm_pkg::CFG_VOL_CEILING};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_we = 1'b1;
      cfg_index = order[i];
      cfg_wdata = vals[i];
      case (order[i])
        amfm_pkg::CFG_AM_LOWEST:  am_lo = vals[i];
        amfm_pkg::CFG_AM_HIGHEST: am_hi = vals[i];
        amfm_pkg::CFG_FM_LOWEST:  fm_lo = vals[i];
        amfm_pkg::CFG_FM_HIGHEST: fm_hi = vals[i];
        default:                  vol_ceil = vals[i][VW-1:0];
      endcase
    end
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_random();
    int pick;
    int v;
    amfm_pkg::req_t req;
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    logic [SW-1:0] sval;
    logic [VRW-1:0] vraw;
    logic [BW-1:0] btn;
    pick = $urandom_range(0, 99);
    if (pick < 10) req = amfm_pkg::REQ_POWER;
    else if (pick < 20) req = amfm_pkg::REQ_BAND;
    else if (pick < 35) req = amfm_pkg::REQ_SCAN_UP;
    else if (pick < 50) req = amfm_pkg::REQ_SCAN_DOWN;
    else if (pick < 65) req = amfm_pkg::REQ_SET_STATION;
    else if (pick < 80) req = amfm_pkg::REQ_SET_VOLUME;
    else if (pick < 90) req = amfm_pkg::REQ_STORE;
    else req = amfm_pkg::REQ_RECALL;
    lo = on_fm ? fm_lo : am_lo;
    hi = on_fm ? fm_hi : am_hi;
    sval = SW'($urandom_range(0, 2047));
    if (req == amfm_pkg::REQ_SET_STATION && $urandom_range(0, 1) == 1 && lo <= hi) begin
      sval = SW'($urandom_range(lo, hi));
      if (!on_fm) sval = sval - SW'(int'(sval) % AMSTEP);
    end
    case ($urandom_range(0, 5))
      0, 1: v = $urandom_range(0, vol_ceil);
      2: v = -int'($urandom_range(1, 1024));
      3: v = $urandom_range(vol_ceil, 1023);
      default: v = int'($urandom_range(0, 2047)) - 1024;
    endcase
    vraw = v[VRW-1:0];
    if ($urandom_range(0, 3) == 0) btn = BW'($urandom_range(0, 15));
    else btn = BW'($urandom_range(0, PRESETS - 1));
    send_word(req, sval, vraw, btn, 1'b0, '0);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin : result_check
    panel_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        flag_field("unexpected word, station", int'(out_station_now), -1);
      end else begin
        want = pending_words.pop_front();
        checked_words++;
        if (out_status !== want.status)
          flag_field("status", int'(out_status), int'(want.status));
        if (out_power_on !== want.power)
          flag_field("power_on", int'(out_power_on), int'(want.power));
        if (out_band_fm !== want.fm)
          flag_field("band_fm", int'(out_band_fm), int'(want.fm));
        if (out_station_now !== want.station)
          flag_field("station_now", int'(out_station_now), int'(want.station));
        if (out_volume_now !== want.volume)
          flag_field("volume_now", int'(out_volume_now), int'(want.volume));
      end
    end
  end

  // The result side stalls on its own pattern; a long hold-off is served on request.
  initial begin : result_stall
    int mode;
    int seg;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 3);
      seg = $urandom_range(10, 120);
      if (squeeze_served < squeeze_asks) begin
        squeeze_served++;
        mode = 4;
        seg = 80;
      end
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          0: out_stall = 1'b0;
          1: out_stall = ($urandom_range(0, 3) == 0);
          2: out_stall = ($urandom_range(0, 3) != 0);
          3: out_stall = ~out_stall;
          default: out_stall = 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    int burst_left;
    logic [CDW-1:0] vals [5];
    logic [CDW-1:0] lo_pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = amfm_pkg::REQ_POWER;
    in_station_value = '0;
    in_volume_value = '0;
    in_button_index = '0;
    cfg_we = 1'b0;
    cfg_index = amfm_pkg::CFG_AM_LOWEST;
    cfg_wdata = '0;
    burst_left = 0;
    reset_tuner();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (drill_table[i]) begin
      idle_sender($urandom_range(0, 2));
      send_word(drill_table[i].req, drill_table[i].sval, drill_table[i].vraw,
                drill_table[i].btn, drill_table[i].typed, drill_table[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p < 6) begin
        vals = limit_sets[p];
      end else begin
        lo_pick = CDW'($urandom_range(0, 2047));
        vals[0] = lo_pick;
        vals[1] = (int'(lo_pick) + 300 > 2047) ? 11'd2047 :
                  CDW'(int'(lo_pick) + int'($urandom_range(0, 300)));
        lo_pick = CDW'($urandom_range(0, 2047));
        vals[2] = lo_pick;
        vals[3] = (int'(lo_pick) + 100 > 2047) ? 11'd2047 :
                  CDW'(int'(lo_pick) + int'($urandom_range(0, 100)));
        vals[4] = CDW'($urandom_range(1, 127));
      end
      load_limits(vals);
      if (p == 0 || p == 4) squeeze_asks++;
      burst_left = 0;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
          burst_left = $urandom_range(1, 30);
        end
        send_random();
        burst_left--;
      end
    end

    idle_sender(1);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d request words (%0d from the directed table) under %0d limit settings.",
             sent_words, $size(drill_table), PHASES);
    $display("Checked %0d result words; %0d field mismatches; %0d words left pending.",
             checked_words, bad_fields, pending_words.size());
    if (bad_fields == 0 && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Run timed out with %0d words pending.", pending_words.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
